// ===== sv/rkh_pkg.sv =====
// ----------------------------------------------------------------------------
// rkh_pkg
// Shared widths, codes and types of the read k-mer hasher.
// ----------------------------------------------------------------------------
package rkh_pkg;

   localparam int CHAR_W    = 8;
   localparam int CODE_W    = 3;
   localparam int THR_W     = 8;
   localparam int LEN_W     = 11;
   localparam int COUNT_W   = 11;
   localparam int SLOT_W    = 10;
   localparam int SEGNUM_W  = 8;
   localparam int WIN_W     = 10;
   localparam int HASH_W    = 16;
   localparam int KIND_W    = 2;
   localparam int ADDR_W    = 4;
   localparam int DATA_W    = 32;
   localparam int WIN_TAPS  = 3;

   localparam int DEFAULT_MAX_READ_LENGTH = 1024;
   localparam int QUEUE_DEPTH             = 4;

   localparam logic [THR_W-1:0]   THR_RESET    = 8'd4;
   localparam logic [THR_W-1:0]   THR_MAX      = 8'd254;
   localparam logic [LEN_W-1:0]   CROP_RESET   = 11'd0;
   localparam logic [LEN_W-1:0]   SEGLEN_RESET = 11'd20;
   localparam logic [COUNT_W-1:0] COUNT_MAX    = 11'd2047;

   localparam logic [1:0] REG_ERR_THRESHOLD  = 2'd0;
   localparam logic [1:0] REG_CROP_LENGTH    = 2'd1;
   localparam logic [1:0] REG_SEGMENT_LENGTH = 2'd2;

   localparam logic [KIND_W-1:0] KIND_WINDOW  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SEGMENT = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SUMMARY = 2'd2;

   localparam logic [CHAR_W-1:0] CHAR_A       = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_C       = 8'h43;
   localparam logic [CHAR_W-1:0] CHAR_G       = 8'h47;
   localparam logic [CHAR_W-1:0] CHAR_T       = 8'h54;
   localparam logic [CHAR_W-1:0] CHAR_N       = 8'h4E;
   localparam logic [CHAR_W-1:0] CHAR_LOW_A   = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LOW_Z   = 8'h7A;
   localparam logic [CHAR_W-1:0] CASE_OFFSET  = 8'h20;

   localparam logic [CODE_W-1:0] CODE_A     = 3'd0;
   localparam logic [CODE_W-1:0] CODE_C     = 3'd1;
   localparam logic [CODE_W-1:0] CODE_G     = 3'd2;
   localparam logic [CODE_W-1:0] CODE_T     = 3'd3;
   localparam logic [CODE_W-1:0] CODE_OTHER = 3'd4;

   typedef struct packed {
      logic [THR_W-1:0] err_threshold;
      logic [LEN_W-1:0] crop_length;
      logic [LEN_W-1:0] segment_length;
   } cfg_type;

   typedef struct packed {
      logic                win_vld;
      logic [SLOT_W-1:0]   win_slot;
      logic [WIN_W-1:0]    win_hash;
      logic                seg_vld;
      logic [SEGNUM_W-1:0] seg_slot;
      logic [HASH_W-1:0]   seg_hash;
      logic                sum_vld;
      logic [COUNT_W-1:0]  n_total;
      logic                discard;
   } job_type;

endpackage

// ===== sv/read_kmer_hasher_core.sv =====
// ----------------------------------------------------------------------------
// read_kmer_hasher_core
// Rolling base-5 k-mer and segment hasher over a DNA read stream.
// ----------------------------------------------------------------------------
// One base transfer is taken every cycle while the four-entry job queue has
// room. Each base that yields a result becomes one job holding up to three
// results (window hash, segment hash, read summary); the result port issues
// one result per cycle while the receiver is ready, so a base yielding two or
// three results issues them in turn and the queue absorbs the burst. A result
// is registered in the queue and then in the output register. The user must
// write configuration over the register port while idle; the block does not enforce it.
module read_kmer_hasher_core #(
   parameter int MAX_READ_LENGTH = rkh_pkg::DEFAULT_MAX_READ_LENGTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [rkh_pkg::ADDR_W-1:0]    paddr,
   input  logic [rkh_pkg::DATA_W-1:0]    pwdata,
   output logic [rkh_pkg::DATA_W-1:0]    prdata,
   output logic                          pready,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [rkh_pkg::CHAR_W-1:0]    req_base_char,
   input  logic                          req_read_end,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [rkh_pkg::KIND_W-1:0]    rsp_kind,
   output logic [rkh_pkg::SLOT_W-1:0]    rsp_slot,
   output logic [rkh_pkg::HASH_W-1:0]    rsp_hash_value,
   output logic [rkh_pkg::COUNT_W-1:0]   rsp_n_total,
   output logic                          rsp_discard,
   output logic                          rsp_final_flag
);
   import rkh_pkg::*;

   cfg_type cfg;
   job_type push_job;
   job_type head_job;
   logic    push, full, pop, head_valid;

   rkh_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   rkh_front #(
      .MAX_READ_LENGTH (MAX_READ_LENGTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_base_char (req_base_char),
      .req_read_end  (req_read_end),
      .queue_full    (full),
      .push          (push),
      .push_job      (push_job)
   );

   rkh_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   rkh_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head_job       (head_job),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_kind       (rsp_kind),
      .rsp_slot       (rsp_slot),
      .rsp_hash_value (rsp_hash_value),
      .rsp_n_total    (rsp_n_total),
      .rsp_discard    (rsp_discard),
      .rsp_final_flag (rsp_final_flag)
   );

endmodule

// ===== sv/rkh_csr.sv =====
// ----------------------------------------------------------------------------
// rkh_csr
// Configuration registers behind the register bus port.
// ----------------------------------------------------------------------------
module rkh_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [rkh_pkg::ADDR_W-1:0]   paddr,
   input  logic [rkh_pkg::DATA_W-1:0]   pwdata,
   output logic [rkh_pkg::DATA_W-1:0]   prdata,
   output logic                         pready,
   output rkh_pkg::cfg_type             cfg
);
   import rkh_pkg::*;

   logic [THR_W-1:0] thr_ff, thr_in;
   logic [LEN_W-1:0] crop_ff, crop_in;
   logic [LEN_W-1:0] seglen_ff, seglen_in;
   logic             wr_en;
   logic [1:0]       reg_idx;

   assign pready  = 1'b1;
   assign reg_idx = paddr[ADDR_W-1:2];
   assign wr_en   = psel && penable && pwrite;

   always_comb begin
      thr_in    = thr_ff;
      crop_in   = crop_ff;
      seglen_in = seglen_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_ERR_THRESHOLD:  thr_in    = pwdata[THR_W-1:0];
            REG_CROP_LENGTH:    crop_in   = pwdata[LEN_W-1:0];
            REG_SEGMENT_LENGTH: seglen_in = pwdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_ERR_THRESHOLD:  prdata = DATA_W'(thr_ff);
         REG_CROP_LENGTH:    prdata = DATA_W'(crop_ff);
         REG_SEGMENT_LENGTH: prdata = DATA_W'(seglen_ff);
         default:            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff    <= THR_RESET;
         crop_ff   <= CROP_RESET;
         seglen_ff <= SEGLEN_RESET;
      end else begin
         thr_ff    <= thr_in;
         crop_ff   <= crop_in;
         seglen_ff <= seglen_in;
      end
   end

   assign cfg.err_threshold  = thr_ff;
   assign cfg.crop_length    = crop_ff;
   assign cfg.segment_length = seglen_ff;

endmodule

// ===== sv/rkh_front.sv =====
// ----------------------------------------------------------------------------
// rkh_front
// Base intake: codes each base, advances the read state and forms a job.
// ----------------------------------------------------------------------------
module rkh_front #(
   parameter int MAX_READ_LENGTH = rkh_pkg::DEFAULT_MAX_READ_LENGTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  rkh_pkg::cfg_type             cfg,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [rkh_pkg::CHAR_W-1:0]   req_base_char,
   input  logic                         req_read_end,
   input  logic                         queue_full,
   output logic                         push,
   output rkh_pkg::job_type             push_job
);
   import rkh_pkg::*;

   localparam int POS_W = $clog2(MAX_READ_LENGTH + 1);
   localparam int CMP_W = (POS_W > LEN_W) ? POS_W : LEN_W;
   localparam logic [CMP_W-1:0] MAX_LEN = CMP_W'(MAX_READ_LENGTH);

   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [CODE_W-1:0]   taps_ff [WIN_TAPS], taps_in [WIN_TAPS];
   logic [COUNT_W-1:0]  n_ff, n_in;
   logic [HASH_W-1:0]   acc_ff, acc_in;
   logic [SEGNUM_W-1:0] segnum_ff, segnum_in;
   logic [LEN_W-1:0]    fill_ff, fill_in;

   logic                take;
   logic [CHAR_W-1:0]   upper;
   logic [CODE_W-1:0]   code;
   logic [THR_W-1:0]    thr;
   logic [CMP_W-1:0]    limit;
   logic                keep;
   logic                seg_active;
   logic [HASH_W-1:0]   acc_next;
   logic [LEN_W-1:0]    fill_next;
   logic                seg_done;
   logic [COUNT_W-1:0]  n_next;

   assign req_ready = !queue_full;
   assign take      = req_valid && req_ready;

   always_comb begin
      upper = req_base_char;
      if (req_base_char inside {[CHAR_LOW_A:CHAR_LOW_Z]}) begin
         upper = req_base_char - CASE_OFFSET;
      end
      case (upper)
         CHAR_A:  code = CODE_A;
         CHAR_C:  code = CODE_C;
         CHAR_G:  code = CODE_G;
         CHAR_T:  code = CODE_T;
         default: code = CODE_OTHER;
      endcase
   end

   assign thr   = (cfg.err_threshold > THR_MAX) ? THR_MAX : cfg.err_threshold;
   assign limit = (cfg.crop_length != '0 && CMP_W'(cfg.crop_length) < MAX_LEN)
                  ? CMP_W'(cfg.crop_length) : MAX_LEN;
   assign keep  = CMP_W'(pos_ff) < limit;

   assign seg_active = keep && (cfg.segment_length != '0) && (segnum_ff <= thr);
   assign acc_next   = {acc_ff[HASH_W-3:0], 2'b00} + acc_ff + HASH_W'(code);
   assign fill_next  = fill_ff + LEN_W'(1);
   assign seg_done   = seg_active && (fill_next >= cfg.segment_length);
   assign n_next     = (keep && upper == CHAR_N && n_ff < COUNT_MAX)
                       ? n_ff + COUNT_W'(1) : n_ff;

   always_comb begin
      push_job.win_vld  = keep && (pos_ff >= POS_W'(3));
      push_job.win_slot = SLOT_W'(pos_ff - POS_W'(3));
      push_job.win_hash = WIN_W'(taps_ff[2]) * WIN_W'(125)
                        + WIN_W'(taps_ff[1]) * WIN_W'(25)
                        + WIN_W'(taps_ff[0]) * WIN_W'(5)
                        + WIN_W'(code);
      push_job.seg_vld  = seg_done;
      push_job.seg_slot = segnum_ff;
      push_job.seg_hash = acc_next;
      push_job.sum_vld  = req_read_end;
      push_job.n_total  = n_next;
      push_job.discard  = n_next > COUNT_W'(thr);
   end

   assign push = take && (push_job.win_vld || push_job.seg_vld || push_job.sum_vld);

   always_comb begin
      pos_in    = pos_ff;
      taps_in   = taps_ff;
      n_in      = n_ff;
      acc_in    = acc_ff;
      segnum_in = segnum_ff;
      fill_in   = fill_ff;
      if (take) begin
         if (keep) begin
            pos_in     = pos_ff + POS_W'(1);
            taps_in[0] = code;
            taps_in[1] = taps_ff[0];
            taps_in[2] = taps_ff[1];
            n_in       = n_next;
         end
         if (seg_active) begin
            if (seg_done) begin
               acc_in    = '0;
               fill_in   = '0;
               segnum_in = segnum_ff + SEGNUM_W'(1);
            end else begin
               acc_in  = acc_next;
               fill_in = fill_next;
            end
         end
         if (req_read_end) begin
            pos_in    = '0;
            taps_in   = '{default: '0};
            n_in      = '0;
            acc_in    = '0;
            segnum_in = '0;
            fill_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         taps_ff   <= '{default: '0};
         n_ff      <= '0;
         acc_ff    <= '0;
         segnum_ff <= '0;
         fill_ff   <= '0;
      end else begin
         pos_ff    <= pos_in;
         taps_ff   <= taps_in;
         n_ff      <= n_in;
         acc_ff    <= acc_in;
         segnum_ff <= segnum_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

// ===== sv/rkh_queue.sv =====
// ----------------------------------------------------------------------------
// rkh_queue
// Short job queue between base intake and result issue.
// ----------------------------------------------------------------------------
module rkh_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rkh_pkg::job_type  push_job,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output rkh_pkg::job_type  head_job
);
   import rkh_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type            slots_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full       = count_ff == CNT_W'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_job   = slots_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== sv/rkh_back.sv =====
// ----------------------------------------------------------------------------
// rkh_back
// Result issue: unpacks each job into window, segment and summary results.
// ----------------------------------------------------------------------------
module rkh_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          head_valid,
   input  rkh_pkg::job_type              head_job,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [rkh_pkg::KIND_W-1:0]    rsp_kind,
   output logic [rkh_pkg::SLOT_W-1:0]    rsp_slot,
   output logic [rkh_pkg::HASH_W-1:0]    rsp_hash_value,
   output logic [rkh_pkg::COUNT_W-1:0]   rsp_n_total,
   output logic                          rsp_discard,
   output logic                          rsp_final_flag
);
   import rkh_pkg::*;

   logic [2:0]          done_ff, done_in;
   logic                valid_ff, valid_in;
   logic [KIND_W-1:0]   kind_ff, kind_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic [HASH_W-1:0]   hash_ff, hash_in;
   logic [COUNT_W-1:0]  ntot_ff, ntot_in;
   logic                disc_ff, disc_in;
   logic                final_ff, final_in;

   logic [2:0]          pending;
   logic [2:0]          pick;
   logic                load;

   assign pending = {head_job.sum_vld, head_job.seg_vld, head_job.win_vld} & ~done_ff;
   assign load    = head_valid && (!valid_ff || rsp_ready);

   always_comb begin
      pick    = 3'b000;
      kind_in = kind_ff;
      slot_in = slot_ff;
      hash_in = hash_ff;
      ntot_in = ntot_ff;
      disc_in = disc_ff;
      if (pending[0]) begin
         pick    = 3'b001;
         kind_in = KIND_WINDOW;
         slot_in = head_job.win_slot;
         hash_in = HASH_W'(head_job.win_hash);
         ntot_in = '0;
         disc_in = 1'b0;
      end else if (pending[1]) begin
         pick    = 3'b010;
         kind_in = KIND_SEGMENT;
         slot_in = SLOT_W'(head_job.seg_slot);
         hash_in = head_job.seg_hash;
         ntot_in = '0;
         disc_in = 1'b0;
      end else begin
         pick    = 3'b100;
         kind_in = KIND_SUMMARY;
         slot_in = '0;
         hash_in = '0;
         ntot_in = head_job.n_total;
         disc_in = head_job.discard;
      end
      final_in = (pending & ~pick) == 3'b000;
      if (!load) begin
         kind_in  = kind_ff;
         slot_in  = slot_ff;
         hash_in  = hash_ff;
         ntot_in  = ntot_ff;
         disc_in  = disc_ff;
         final_in = final_ff;
      end
   end

   assign pop = load && final_in;

   always_comb begin
      done_in  = done_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
         done_in  = final_in ? 3'b000 : (done_ff | pick);
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         done_ff  <= done_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      slot_ff  <= slot_in;
      hash_ff  <= hash_in;
      ntot_ff  <= ntot_in;
      disc_ff  <= disc_in;
      final_ff <= final_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_kind       = kind_ff;
   assign rsp_slot       = slot_ff;
   assign rsp_hash_value = hash_ff;
   assign rsp_n_total    = ntot_ff;
   assign rsp_discard    = disc_ff;
   assign rsp_final_flag = final_ff;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for read_kmer_hasher_core. A directed table of bases
// and then random reads are streamed over the valid/ready base channel, with
// the register port reprogrammed between phases. An in-bench model of the
// window, segment and summary hashing predicts each result not given in the
// directed table, and each result transfer is compared field by field, in order.
// ----------------------------------------------------------------------------
module tb;
   import rkh_pkg::*;

   localparam int PERIOD_HALF  = 4;
   localparam int RESET_CYCLES = 3;
   localparam int STALL_LIMIT  = 2000;
   localparam int HOLD_CYCLES  = 300;
   localparam int HOLD_AFTER   = 80;
   localparam int DRAIN_PAD    = 8;
   localparam int PHASE_BASES  = 40;
   localparam int PRINT_CAP    = 100;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [SLOT_W-1:0]  slot;
      logic [HASH_W-1:0]  hash_value;
      logic [COUNT_W-1:0] n_total;
      logic               discard;
      logic               final_flag;
   } hash_result_type;

   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              last;
      logic              typed;
      hash_result_type   want;
   } base_row_type;

   localparam hash_result_type NO_RESULT = '0;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [ADDR_W-1:0]   paddr = '0;
   logic [DATA_W-1:0]   pwdata = '0;
   logic [DATA_W-1:0]   prdata;
   logic                pready;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [CHAR_W-1:0]   req_base_char = '0;
   logic                req_read_end = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [KIND_W-1:0]   rsp_kind;
   logic [SLOT_W-1:0]   rsp_slot;
   logic [HASH_W-1:0]   rsp_hash_value;
   logic [COUNT_W-1:0]  rsp_n_total;
   logic                rsp_discard;
   logic                rsp_final_flag;

   // predictor configuration and per-read state
   logic [THR_W-1:0]    thr_cfg = THR_RESET;
   logic [LEN_W-1:0]    crop_cfg = CROP_RESET;
   logic [LEN_W-1:0]    seglen_cfg = SEGLEN_RESET;
   logic [WIN_W-1:0]    win_acc = '0;
   logic [LEN_W-1:0]    kept_count = '0;
   logic [COUNT_W-1:0]  n_seen = '0;
   logic [HASH_W-1:0]   seg_acc = '0;
   logic [SEGNUM_W-1:0] seg_idx = '0;
   logic [LEN_W-1:0]    seg_fill = '0;

   hash_result_type results_due[$];
   hash_result_type new_results[$];
   base_row_type    directed_rows[$];

   int  mismatch_count = 0;
   int  bases_sent = 0;
   int  results_seen = 0;
   int  kind_seen[3] = '{0, 0, 0};
   int  settings_used = 1;
   bit  idle_free = 1'b0;

   read_kmer_hasher_core dut (
      .clock          (clock),
      .reset          (reset),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_base_char  (req_base_char),
      .req_read_end   (req_read_end),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_kind       (rsp_kind),
      .rsp_slot       (rsp_slot),
      .rsp_hash_value (rsp_hash_value),
      .rsp_n_total    (rsp_n_total),
      .rsp_discard    (rsp_discard),
      .rsp_final_flag (rsp_final_flag)
   );

   always begin
      #PERIOD_HALF clock = 1'b1;
      #PERIOD_HALF clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP) begin
         $display("MISMATCH at %0t: %s", $time, what);
      end
   endtask

   function automatic void predict_hashes(input logic [CHAR_W-1:0] ch_in,
                                          input logic last);
      logic [CHAR_W-1:0] ch;
      logic [CODE_W-1:0] code;
      logic [THR_W-1:0]  thr_eff;
      logic [LEN_W-1:0]  limit;
      logic [LEN_W-1:0]  win_start;
      hash_result_type   r;
      new_results.delete();
      thr_eff = (thr_cfg > THR_MAX) ? THR_MAX : thr_cfg;
      limit = LEN_W'(DEFAULT_MAX_READ_LENGTH);
      if (crop_cfg != '0 && crop_cfg < limit) limit = crop_cfg;
      ch = ch_in;
      if (ch >= CHAR_LOW_A && ch <= CHAR_LOW_Z) ch = ch - CASE_OFFSET;
      if (kept_count < limit) begin
         case (ch)
            CHAR_A:  code = CODE_A;
            CHAR_C:  code = CODE_C;
            CHAR_G:  code = CODE_G;
            CHAR_T:  code = CODE_T;
            default: code = CODE_OTHER;
         endcase
         kept_count++;
         if (ch == CHAR_N && n_seen < COUNT_MAX) n_seen++;
         win_acc = WIN_W'((win_acc % 125) * 5 + code);
         if (kept_count >= 4) begin
            win_start = kept_count - LEN_W'(4);
            r = NO_RESULT;
            r.kind = KIND_WINDOW;
            r.slot = win_start[SLOT_W-1:0];
            r.hash_value = HASH_W'(win_acc);
            new_results.push_back(r);
         end
         if (seglen_cfg != '0 && seg_idx <= thr_eff) begin
            seg_acc = HASH_W'(seg_acc * 5 + code);
            seg_fill++;
            if (seg_fill >= seglen_cfg) begin
               r = NO_RESULT;
               r.kind = KIND_SEGMENT;
               r.slot = SLOT_W'(seg_idx);
               r.hash_value = seg_acc;
               new_results.push_back(r);
               seg_acc = '0;
               seg_fill = '0;
               seg_idx++;
            end
         end
      end
      if (last) begin
         r = NO_RESULT;
         r.kind = KIND_SUMMARY;
         r.n_total = n_seen;
         r.discard = (n_seen > COUNT_W'(thr_eff));
         new_results.push_back(r);
         win_acc = '0;
         kept_count = '0;
         n_seen = '0;
         seg_acc = '0;
         seg_idx = '0;
         seg_fill = '0;
      end
      if (new_results.size() > 0) new_results[new_results.size()-1].final_flag = 1'b1;
   endfunction

   // one base transfer, then queue what it should produce
   task automatic stream_base(input logic [CHAR_W-1:0] ch, input logic last,
                              input logic typed, input hash_result_type want);
      while (!idle_free && $urandom_range(0, 99) < 20) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_base_char <= ch;
      req_read_end <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bases_sent++;
      predict_hashes(ch, last);
      if (typed) begin
         results_due.push_back(want);
      end else begin
         foreach (new_results[i]) results_due.push_back(new_results[i]);
      end
   endtask

   function automatic logic [CHAR_W-1:0] random_base_char();
      int                pick;
      logic [CHAR_W-1:0] ch;
      pick = $urandom_range(0, 99);
      if (pick < 15) return CHAR_W'($urandom_range(0, 255));
      case ($urandom_range(0, 4))
         0:       ch = CHAR_A;
         1:       ch = CHAR_C;
         2:       ch = CHAR_G;
         3:       ch = CHAR_T;
         default: ch = CHAR_N;
      endcase
      if (pick < 30) ch = ch + CASE_OFFSET;
      return ch;
   endfunction

   task automatic write_register(input logic [1:0] index, input logic [DATA_W-1:0] value);
      logic [DATA_W-1:0] mask;
      mask = (index == REG_ERR_THRESHOLD) ? DATA_W'(8'hFF) : DATA_W'(11'h7FF);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if ((prdata & mask) !== (value & mask)) begin
         report_mismatch($sformatf("register %0d read %0h, written %0h", index, prdata,
                                   value));
      end
      psel <= 1'b0;
      penable <= 1'b0;
      case (index)
         REG_ERR_THRESHOLD:  thr_cfg = value[THR_W-1:0];
         REG_CROP_LENGTH:    crop_cfg = value[LEN_W-1:0];
         REG_SEGMENT_LENGTH: seglen_cfg = value[LEN_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic wait_until_drained();
      while (results_due.size() != 0) @(posedge clock);
      repeat (DRAIN_PAD) @(posedge clock);
   endtask

   task automatic check_result();
      hash_result_type want;
      results_seen++;
      if (rsp_kind < 3) kind_seen[rsp_kind]++;
      if (results_due.size() == 0) begin
         report_mismatch($sformatf("result %0d with nothing due (kind %0d slot %0d)",
                                   results_seen, rsp_kind, rsp_slot));
         return;
      end
      want = results_due.pop_front();
      if (rsp_kind !== want.kind)
         report_mismatch($sformatf("result %0d kind %0d, want %0d", results_seen,
                                   rsp_kind, want.kind));
      if (rsp_slot !== want.slot)
         report_mismatch($sformatf("result %0d slot %0d, want %0d", results_seen,
                                   rsp_slot, want.slot));
      if (rsp_hash_value !== want.hash_value)
         report_mismatch($sformatf("result %0d hash %0d, want %0d", results_seen,
                                   $signed(rsp_hash_value), $signed(want.hash_value)));
      if (rsp_n_total !== want.n_total)
         report_mismatch($sformatf("result %0d n_total %0d, want %0d", results_seen,
                                   rsp_n_total, want.n_total));
      if (rsp_discard !== want.discard)
         report_mismatch($sformatf("result %0d discard %0b, want %0b", results_seen,
                                   rsp_discard, want.discard));
      if (rsp_final_flag !== want.final_flag)
         report_mismatch($sformatf("result %0d final_flag %0b, want %0b", results_seen,
                                   rsp_final_flag, want.final_flag));
   endtask

   // result side: random stalls, one long hold to back the block up
   initial begin : result_side
      int hold_left;
      bit held_once;
      hold_left = 0;
      held_once = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) check_result();
         if (!held_once && bases_sent >= HOLD_AFTER) begin
            held_once = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= idle_free || ($urandom_range(0, 99) >= 20);
         end
      end
   end

   always @(posedge clock) begin : watchdog
      int quiet;
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet = 0;
      end else begin
         quiet++;
         if (quiet >= STALL_LIMIT) begin
            $display("Stalled for %0d cycles with %0d results due", quiet,
                     results_due.size());
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int              phase_thr[7];
      int              phase_crop[7];
      int              phase_seglen[7];
      int              phase_count;
      int              read_len;
      logic            typed;
      hash_result_type want;
      phase_thr    = '{4, 0, 254, 2, 1, 3, 255};
      phase_crop   = '{0, 0, 1024, 7, 0, 1, 2047};
      phase_seglen = '{20, 1, 1, 2, 0, 1024, 3};

      // reset defaults: threshold 4, no crop, segments of 20
      directed_rows.push_back('{CHAR_N, 1'b1, 1'b1,
                                '{KIND_SUMMARY, 10'd0, 16'd0, 11'd1, 1'b0, 1'b1}});
      directed_rows.push_back('{CHAR_LOW_A, 1'b0, 1'b0, NO_RESULT});
      directed_rows.push_back('{CHAR_C + CASE_OFFSET, 1'b0, 1'b0, NO_RESULT});
      directed_rows.push_back('{CHAR_G + CASE_OFFSET, 1'b0, 1'b0, NO_RESULT});
      directed_rows.push_back('{CHAR_T + CASE_OFFSET, 1'b0, 1'b1,
                                '{KIND_WINDOW, 10'd0, 16'd38, 11'd0, 1'b0, 1'b1}});
      directed_rows.push_back('{CHAR_T, 1'b0, 1'b0, NO_RESULT});
      directed_rows.push_back('{8'hFF, 1'b0, 1'b0, NO_RESULT});
      directed_rows.push_back('{8'h00, 1'b0, 1'b0, NO_RESULT});
      directed_rows.push_back('{8'h20, 1'b0, 1'b0, NO_RESULT});
      directed_rows.push_back('{CHAR_LOW_Z, 1'b0, 1'b0, NO_RESULT});
      directed_rows.push_back('{CHAR_LOW_Z - CASE_OFFSET, 1'b0, 1'b0, NO_RESULT});
      directed_rows.push_back('{CHAR_A - 8'd1, 1'b0, 1'b0, NO_RESULT});
      directed_rows.push_back('{CHAR_LOW_Z - CASE_OFFSET + 8'd1, 1'b0, 1'b0, NO_RESULT});
      directed_rows.push_back('{CHAR_LOW_A - 8'd1, 1'b0, 1'b0, NO_RESULT});
      directed_rows.push_back('{CHAR_LOW_Z + 8'd1, 1'b0, 1'b0, NO_RESULT});
      directed_rows.push_back('{CHAR_G, 1'b0, 1'b0, NO_RESULT});
      directed_rows.push_back('{CHAR_N, 1'b0, 1'b0, NO_RESULT});
      directed_rows.push_back('{CHAR_N + CASE_OFFSET, 1'b0, 1'b0, NO_RESULT});
      directed_rows.push_back('{CHAR_N, 1'b0, 1'b0, NO_RESULT});
      directed_rows.push_back('{CHAR_N, 1'b0, 1'b0, NO_RESULT});
      directed_rows.push_back('{CHAR_N, 1'b1, 1'b0, NO_RESULT});
      directed_rows.push_back('{CHAR_C, 1'b1, 1'b1,
                                '{KIND_SUMMARY, 10'd0, 16'd0, 11'd0, 1'b0, 1'b1}});
      directed_rows.push_back('{8'h80, 1'b1, 1'b1,
                                '{KIND_SUMMARY, 10'd0, 16'd0, 11'd0, 1'b0, 1'b1}});

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         typed = directed_rows[i].typed;
         want = directed_rows[i].want;
         stream_base(directed_rows[i].ch, directed_rows[i].last, typed, want);
      end
      req_valid <= 1'b0;

      for (int p = 0; p < 7; p++) begin
         wait_until_drained();
         write_register(REG_ERR_THRESHOLD, DATA_W'(phase_thr[p]));
         write_register(REG_CROP_LENGTH, DATA_W'(phase_crop[p]));
         write_register(REG_SEGMENT_LENGTH, DATA_W'(phase_seglen[p]));
         settings_used++;
         idle_free = (p == 2);
         phase_count = 0;
         while (phase_count < PHASE_BASES) begin
            read_len = ($urandom_range(0, 9) == 0) ? $urandom_range(31, 80)
                                                   : $urandom_range(1, 30);
            for (int j = 0; j < read_len; j++) begin
               stream_base(random_base_char(), j == read_len - 1, 1'b0, NO_RESULT);
            end
            phase_count += read_len;
         end
         req_valid <= 1'b0;
      end

      wait_until_drained();
      $display("Covered %0d base transfers and %0d result transfers over %0d settings.",
               bases_sent, results_seen, settings_used);
      $display("Results by kind: %0d window, %0d segment, %0d summary; %0d mismatches.",
               kind_seen[0], kind_seen[1], kind_seen[2], mismatch_count);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
